// ===== hdl/irn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, constants and widths of the nearest-neighbor rotation core.
// ----------------------------------------------------------------------------
package irn_pkg;

	// Frame store geometry and coefficient format.
	localparam int MAX_DIM        = 512;
	localparam int COEF_FRAC_BITS = 14;

	// Fixed field widths.
	localparam int COORD_W = 9;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int DIMR_W  = 10;
	localparam int COEF_W  = 16;

	// Derived widths: address per axis, dimension value, signed offset,
	// product and sum.
	localparam int AW     = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int DW     = ((COORD_W > DIM_W) ? COORD_W : DIM_W) + 1;
	localparam int PW     = DW + COEF_W;
	localparam int OFS_W  = DIM_W + COEF_FRAC_BITS;
	localparam int SW     = ((PW > OFS_W) ? PW : OFS_W) + 2;

	// Stream word widths.
	localparam int S_DATA_W = ((2 * COORD_W + PIX_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((PIX_W + 7) / 8) * 8;

	// Item function codes.
	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_COS    = 2'd2,
		REG_SIN    = 2'd3
	} reg_idx_t;

	// Effective configuration seen by the mapping pipeline.
	typedef struct packed {
		logic [DIM_W-1:0]         eff_w;
		logic [DIM_W-1:0]         eff_h;
		logic [DIM_W-1:0]         x0;
		logic [DIM_W-1:0]         y0;
		logic signed [COEF_W-1:0] cos_c;
		logic signed [COEF_W-1:0] sin_c;
	} cfg_t;

	// Frame access issued by the mapping pipeline.
	typedef struct packed {
		logic             valid;
		logic             is_read;
		logic             in_range;
		logic [AW-1:0]    addr_y;
		logic [AW-1:0]    addr_x;
		logic [PIX_W-1:0] pixel;
	} frame_cmd_t;

endpackage

// ===== hdl/irn_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_cfg
// Configuration registers and the effective dimensions and center point.
// ----------------------------------------------------------------------------
module irn_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [irn_pkg::COEF_W-1:0] cfg_wdata,
	output irn_pkg::cfg_t              cfg
);
	import irn_pkg::*;

	logic [DIMR_W-1:0]         width_q;
	logic [DIMR_W-1:0]         height_q;
	logic signed [COEF_W-1:0]  cos_q;
	logic signed [COEF_W-1:0]  sin_q;
	logic [DIM_W-1:0]          eff_w;
	logic [DIM_W-1:0]          eff_h;

	// Register writes; an unknown index cannot occur with a two-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIMR_W'(512);
			height_q <= DIMR_W'(512);
			cos_q    <= COEF_W'(16384);
			sin_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_wdata[DIMR_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[DIMR_W-1:0];
				REG_COS:    cos_q    <= cfg_wdata;
				REG_SIN:    sin_q    <= cfg_wdata;
			endcase
		end
	end

	// Dimensions above the store size are clamped to it.
	always_comb begin
		eff_w = (32'(width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_q);
		eff_h = (32'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_q);
		cfg.eff_w = eff_w;
		cfg.eff_h = eff_h;
		cfg.x0    = eff_w >> 1;
		cfg.y0    = eff_h >> 1;
		cfg.cos_c = cos_q;
		cfg.sin_c = sin_q;
	end

endmodule

// ===== hdl/irn_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_map
// Three-stage coordinate pipeline: input register, products, then sums,
// truncation and bounds check that produce one frame access per word.
// ----------------------------------------------------------------------------
module irn_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic                        in_func,
	input  logic [irn_pkg::COORD_W-1:0] in_col,
	input  logic [irn_pkg::COORD_W-1:0] in_row,
	input  logic [irn_pkg::PIX_W-1:0]   in_pixel,
	input  irn_pkg::cfg_t               cfg,
	output irn_pkg::frame_cmd_t         cmd
);
	import irn_pkg::*;

	// Stage 1: captured input word.
	logic               valid_s1;
	logic               func_s1;
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic [PIX_W-1:0]   pixel_s1;

	// Stage 2: products.
	logic               valid_s2;
	logic               func_s2;
	logic [COORD_W-1:0] col_s2;
	logic [COORD_W-1:0] row_s2;
	logic [PIX_W-1:0]   pixel_s2;
	logic signed [PW-1:0] xc_s2;
	logic signed [PW-1:0] ys_s2;
	logic signed [PW-1:0] xs_s2;
	logic signed [PW-1:0] yc_s2;

	// Stage 3: frame access.
	frame_cmd_t cmd_s3;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic                 rd_inside;
	logic                 wr_inside;
	frame_cmd_t           cmd_d;

	// Valid bits of stages 1 and 2, and the whole stage 3 access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cmd_s3   <= '0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			cmd_s3   <= cmd_d;
		end
	end

	// Offsets from the center.
	always_comb begin
		dx = DW'($signed({1'b0, col_s1})) - DW'($signed({1'b0, cfg.x0}));
		dy = DW'($signed({1'b0, row_s1})) - DW'($signed({1'b0, cfg.y0}));
	end

	// Payload of stages 1 and 2.
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1  <= in_func;
			col_s1   <= in_col;
			row_s1   <= in_row;
			pixel_s1 <= in_pixel;
			func_s2  <= func_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pixel_s2 <= pixel_s1;
			xc_s2    <= dx * cfg.cos_c;
			ys_s2    <= dy * cfg.sin_c;
			xs_s2    <= dx * cfg.sin_c;
			yc_s2    <= dy * cfg.cos_c;
		end
	end

	// Rotated source position, truncated toward zero, and bounds checks.
	always_comb begin
		sum_x = SW'(xc_s2) - SW'(ys_s2)
			+ (SW'($signed({1'b0, cfg.x0})) <<< COEF_FRAC_BITS);
		sum_y = SW'(xs_s2) + SW'(yc_s2)
			+ (SW'($signed({1'b0, cfg.y0})) <<< COEF_FRAC_BITS);
		// A negative sum gets a bias so the arithmetic shift rounds toward zero.
		sx = (sum_x + (sum_x[SW-1] ? SW'((1 << COEF_FRAC_BITS) - 1) : SW'(0)))
			>>> COEF_FRAC_BITS;
		sy = (sum_y + (sum_y[SW-1] ? SW'((1 << COEF_FRAC_BITS) - 1) : SW'(0)))
			>>> COEF_FRAC_BITS;
		rd_inside = !sx[SW-1] && (sx < SW'($signed({1'b0, cfg.eff_w})))
			&& !sy[SW-1] && (sy < SW'($signed({1'b0, cfg.eff_h})));
		wr_inside = (32'(col_s2) < MAX_DIM) && (32'(row_s2) < MAX_DIM);

		cmd_d.valid   = valid_s2;
		cmd_d.is_read = (func_s2 == FUNC_FETCH);
		cmd_d.pixel   = pixel_s2;
		if (func_s2 == FUNC_FETCH) begin
			cmd_d.in_range = rd_inside;
			cmd_d.addr_x   = sx[AW-1:0];
			cmd_d.addr_y   = sy[AW-1:0];
		end else begin
			cmd_d.in_range = wr_inside;
			cmd_d.addr_x   = AW'(col_s2);
			cmd_d.addr_y   = AW'(row_s2);
		end
	end

	assign cmd = cmd_s3;

endmodule

// ===== hdl/irn_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_frame
// Source frame memory with one access per cycle unless stalled, and the
// registered result word that drives the output stream.
// ----------------------------------------------------------------------------
module irn_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  irn_pkg::frame_cmd_t       cmd,
	output logic                      out_valid,
	output logic [irn_pkg::PIX_W-1:0] out_pixel,
	output logic                      out_outside
);
	import irn_pkg::*;

	logic [PIX_W-1:0] mem [2**(2*AW)];
	logic [PIX_W-1:0] rdata_q;
	logic             valid_q;
	logic             outside_q;
	logic [2*AW-1:0]  addr;

	assign addr = {cmd.addr_y, cmd.addr_x};

	// Memory port: a store word writes, every word reads the same address.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd.valid && !cmd.is_read && cmd.in_range) begin
				mem[addr] <= cmd.pixel;
			end
			rdata_q <= mem[addr];
		end
	end

	// Result word control: only fetch words give a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			outside_q <= 1'b0;
		end else if (advance) begin
			valid_q   <= cmd.valid && cmd.is_read;
			outside_q <= !cmd.in_range;
		end
	end

	assign out_valid   = valid_q;
	assign out_outside = outside_q;
	assign out_pixel   = outside_q ? '0 : rdata_q;

`ifndef SYNTHESIS
	// An outside result is black.
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_outside |-> out_pixel == '0)
		else $error("outside result carries a nonzero pixel");

	// A store word never produces a result.
	a_store_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd.valid && !cmd.is_read |=> !out_valid)
		else $error("store word produced a result");

	// A result holds while the pipeline is stalled.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !advance |=> out_valid && $stable(out_outside)
			&& $stable(out_pixel))
		else $error("result changed during a stall");
`endif

endmodule

// ===== hdl/image_rotation_nearest_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_rotation_nearest_core
// Nearest-neighbor image rotation about the image center by inverse mapping.
// ----------------------------------------------------------------------------
// Usage: store words (tuser = 0) write one RGB pixel into the source frame;
// fetch words (tuser = 1) name an output pixel and return one result word,
// the source pixel at the rotated position or black with the outside flag.
// The block takes one word per cycle unless the output stalls. A fetch result
// passes the input register, the multiply stage, the add and bounds stage,
// then the frame memory read into the output register. The single frame
// memory port does one access per cycle unless stalled, and store and fetch
// words reach it in arrival order, so a fetch sees every earlier store. While
// the output word is not taken the whole pipeline holds, and s_tready drops.
// Pixels never written read as arbitrary values. Configuration must be
// written only while no words are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module image_rotation_nearest_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// tdata from bit 0: col[8:0], row[8:0], red_in, green_in, blue_in, zero fill.
	input  logic [irn_pkg::S_DATA_W-1:0] s_tdata,
	// tuser: func.
	input  logic                         s_tuser,
	// Output stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tdata from bit 0: red_out, green_out, blue_out.
	output logic [irn_pkg::M_DATA_W-1:0] m_tdata,
	// tuser: outside.
	output logic                         m_tuser,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [irn_pkg::COEF_W-1:0]   cfg_wdata
);
	import irn_pkg::*;

	cfg_t             cfg;
	frame_cmd_t       cmd;
	logic             advance;
	logic             out_valid;
	logic [PIX_W-1:0] out_pixel;
	logic [PIX_W-1:0] in_pixel;

	// The pipeline moves whenever the output register is empty or being taken.
	assign advance  = !out_valid || m_tready;
	assign s_tready = advance;

	// Stored pixel layout: red in the top byte, blue in the bottom byte.
	assign in_pixel = {s_tdata[2*COORD_W +: CHAN_W],
		s_tdata[2*COORD_W+CHAN_W +: CHAN_W],
		s_tdata[2*COORD_W+2*CHAN_W +: CHAN_W]};

	irn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irn_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_col   (s_tdata[COORD_W-1:0]),
		.in_row   (s_tdata[2*COORD_W-1:COORD_W]),
		.in_pixel (in_pixel),
		.cfg      (cfg),
		.cmd      (cmd)
	);

	irn_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_pixel   (out_pixel),
		.out_outside (m_tuser)
	);

	// Output word: red in the lowest byte.
	assign m_tvalid = out_valid;
	assign m_tdata  = M_DATA_W'({out_pixel[CHAN_W-1:0],
		out_pixel[2*CHAN_W-1:CHAN_W],
		out_pixel[3*CHAN_W-1:2*CHAN_W]});

endmodule

// ===== sim/image_rotation_nearest_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_rotation_nearest_core_tb
// Self-checking bench for the nearest-neighbor rotation core.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, the identity setting, the
// truncation of small negative sums, zero and oversized dimensions,
// requests beyond the image, and coefficients beyond one. Random phases
// follow, each with its own register setting. Every fetch word without a
// fixed result is predicted from a local copy of the frame and registers.
// A fetch that would land on a pixel never stored is preceded by a store
// word to that pixel. Both stream sides stall at random, except in one phase.
// ----------------------------------------------------------------------------
module image_rotation_nearest_core_tb;
	import irn_pkg::*;

	localparam int FRAME_WORDS     = MAX_DIM * MAX_DIM;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TIMEOUT_NS      = 1_000_000;
	localparam int N_PLAN          = 32;
	localparam int N_PHASES        = 10;
	localparam int WORDS_PER_PHASE = 31;
	localparam int IDLE_PCT        = 22;
	localparam int STORE_PCT       = 35;
	localparam int MAX_REPORTS     = 10;

	// One result word split into its fields.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              outside;
	} pixel_result_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_FETCH,
		OP_CFG
	} step_kind_t;

	// One row of the directed table. A set "fixed" bit means the expected
	// result is given in the row rather than by the predictor.
	typedef struct packed {
		step_kind_t          kind;
		reg_idx_t            ridx;
		logic [COEF_W-1:0]   rval;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [PIX_W-1:0]    rgb;
		logic                fixed;
		pixel_result_t       known;
	} plan_step_t;

	localparam pixel_result_t BLACK_OUT = '{8'h00, 8'h00, 8'h00, 1'b1};

	localparam plan_step_t PLAN [N_PLAN] = '{
		// Identity setting after reset: corners of the frame.
		'{OP_STORE, REG_WIDTH, 16'd0, 9'd0, 9'd0, 24'hffffff, 1'b0, '0},
		'{OP_STORE, REG_WIDTH, 16'd0, 9'd511, 9'd511, 24'h123456, 1'b0, '0},
		'{OP_STORE, REG_WIDTH, 16'd0, 9'd511, 9'd0, 24'hff0080, 1'b0, '0},
		'{OP_STORE, REG_WIDTH, 16'd0, 9'd0, 9'd511, 24'h00ff01, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd0, 9'd0, 24'h0, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd511, 9'd511, 24'h0, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd511, 9'd0, 24'h0, 1'b1, '{8'hff, 8'h00, 8'h80, 1'b0}},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd0, 9'd511, 24'h0, 1'b1, '{8'h00, 8'hff, 8'h01, 1'b0}},
		// Slightly above one: the corner sum is just below zero and stays inside.
		'{OP_CFG, REG_COS, 16'd16385, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd0, 9'd0, 24'h0, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}},
		// Zero width: everything is outside.
		'{OP_CFG, REG_COS, 16'd16384, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_WIDTH, 16'd0, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd10, 9'd10, 24'h0, 1'b1, BLACK_OUT},
		// Oversized dimensions are clamped to the frame size.
		'{OP_CFG, REG_WIDTH, 16'hffff, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_HEIGHT, 16'd600, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd511, 9'd511, 24'h0, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
		// One-pixel image: a request beyond it maps outside.
		'{OP_CFG, REG_WIDTH, 16'd1, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_HEIGHT, 16'd1, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd0, 9'd0, 24'h0, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd1, 9'd0, 24'h0, 1'b1, BLACK_OUT},
		// Quarter turn on the full frame.
		'{OP_CFG, REG_WIDTH, 16'd512, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_HEIGHT, 16'd512, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_COS, 16'd0, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_SIN, 16'd16384, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd100, 9'd200, 24'h0, 1'b0, '0},
		// Coefficients at the ends of their range.
		'{OP_CFG, REG_COS, 16'h8000, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_SIN, 16'h7fff, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd256, 9'd256, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd300, 9'd20, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_COS, 16'h7fff, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_CFG, REG_SIN, 16'h8000, 9'd0, 9'd0, 24'h0, 1'b0, '0},
		'{OP_FETCH, REG_WIDTH, 16'd0, 9'd3, 9'd500, 24'h0, 1'b0, '0}
	};

	// Cosine and sine pairs of a few common angles, Q1.14.
	localparam logic [COEF_W-1:0] TURN_COS [8] = '{
		16'd16384, 16'd0, 16'(-16384), 16'd0,
		16'd14189, 16'd11585, 16'd8192, 16'(-11585)
	};
	localparam logic [COEF_W-1:0] TURN_SIN [8] = '{
		16'd0, 16'd16384, 16'd0, 16'(-16384),
		16'd8192, 16'd11585, 16'(-14189), 16'd11585
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [COEF_W-1:0]   cfg_wdata;

	bit steady = 1'b0;
	int n_bad  = 0;

	// Expected result words in order, and the local copy of the block state.
	pixel_result_t     pending_q [$];
	logic [PIX_W-1:0]  frame_mem [FRAME_WORDS];
	bit                frame_seen [FRAME_WORDS];
	logic [DIMR_W-1:0] width_r;
	logic [DIMR_W-1:0] height_r;
	logic [COEF_W-1:0] cos_r;
	logic [COEF_W-1:0] sin_r;

	image_rotation_nearest_core DUT (.*);

	always #2 clk = ~clk;

	// Receiver side: random back-pressure, none while steady.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Result check. Outputs and m_tready are stable at the falling edge, so a
	// word seen here is the one taken at the next rising edge.
	always @(negedge clk) begin
		pixel_result_t got;
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[CHAN_W-1:0], m_tdata[2*CHAN_W-1:CHAN_W],
				m_tdata[3*CHAN_W-1:2*CHAN_W], m_tuser};
			if (pending_q.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("Unexpected result word: rgb %h %h %h outside %0b",
						got.red, got.green, got.blue, got.outside);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("Result mismatch: expected rgb %h %h %h outside %0b, got rgb %h %h %h outside %0b",
							want.red, want.green, want.blue, want.outside,
							got.red, got.green, got.blue, got.outside);
				end
			end
		end
	end

	// Inverse mapping of an output position into the source frame.
	function automatic bit map_source(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row, output int sx, output int sy);
		longint w, h, x0, y0, c, s, dx, dy, one;
		w   = (width_r > MAX_DIM) ? MAX_DIM : longint'(width_r);
		h   = (height_r > MAX_DIM) ? MAX_DIM : longint'(height_r);
		x0  = w / 2;
		y0  = h / 2;
		c   = longint'($signed(cos_r));
		s   = longint'($signed(sin_r));
		one = longint'(1) << COEF_FRAC_BITS;
		dx  = longint'(col) - x0;
		dy  = longint'(row) - y0;
		// Integer division truncates toward zero, as the block does.
		sx  = int'((dx * c - dy * s + x0 * one) / one);
		sy  = int'((dx * s + dy * c + y0 * one) / one);
		return (sx >= 0 && sx < w && sy >= 0 && sy < h);
	endfunction

	function automatic pixel_result_t rotated_pixel(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row);
		int sx, sy;
		logic [PIX_W-1:0] px;
		if (!map_source(col, row, sx, sy))
			return BLACK_OUT;
		px = frame_mem[sy * MAX_DIM + sx];
		return '{px[23:16], px[15:8], px[7:0], 1'b0};
	endfunction

	// Random coordinate, mostly within the image in use.
	function automatic logic [COORD_W-1:0] pick_coord(input logic [DIMR_W-1:0] dim);
		int e;
		e = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
		if (e == 0 || $urandom_range(0, 99) < 20)
			return COORD_W'($urandom());
		return COORD_W'($urandom_range(0, e - 1));
	endfunction

	// Random dimension with its extremes, upper data bits random.
	function automatic logic [COEF_W-1:0] pick_dim();
		logic [DIMR_W-1:0] d;
		case ($urandom_range(0, 9))
			0: d = 10'd1;
			1: d = 10'd2;
			2: d = 10'd512;
			3: d = 10'd0;
			4: d = DIMR_W'($urandom_range(513, 1023));
			default: d = DIMR_W'($urandom_range(3, 512));
		endcase
		return {6'($urandom()), d};
	endfunction

	// Send one input word and wait until it is taken.
	task automatic push_word(input logic func, input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] rgb);
		bit took;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= S_DATA_W'({rgb[7:0], rgb[15:8], rgb[23:16], row, col});
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic store_pixel(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] rgb);
		push_word(FUNC_STORE, col, row, rgb);
		frame_mem[row * MAX_DIM + col]  = rgb;
		frame_seen[row * MAX_DIM + col] = 1'b1;
	endtask

	// A fetch never lands on an unwritten pixel: fill it first.
	task automatic fetch_pixel(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row, input bit fixed, input pixel_result_t known);
		int sx, sy;
		pixel_result_t want;
		if (map_source(col, row, sx, sy) && !frame_seen[sy * MAX_DIM + sx])
			store_pixel(COORD_W'(sx), COORD_W'(sy), PIX_W'($urandom()));
		want = fixed ? known : rotated_pixel(col, row);
		push_word(FUNC_FETCH, col, row, PIX_W'($urandom()));
		pending_q.push_back(want);
	endtask

	// Let every result word out, then wait out the trailing stores.
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:  width_r  = value[DIMR_W-1:0];
			REG_HEIGHT: height_r = value[DIMR_W-1:0];
			REG_COS:    cos_r    = value;
			REG_SIN:    sin_r    = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Main sequence: reset, directed table, random phases, final report.
	initial begin
		logic [COEF_W-1:0] wv, hv, cv, sv;
		int t;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = FUNC_STORE;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_wdata = '0;
		width_r   = 10'd512;
		height_r  = 10'd512;
		cos_r     = 16'd16384;
		sin_r     = 16'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_PLAN; i++) begin
			case (PLAN[i].kind)
				OP_STORE: store_pixel(PLAN[i].col, PLAN[i].row, PLAN[i].rgb);
				OP_FETCH: fetch_pixel(PLAN[i].col, PLAN[i].row, PLAN[i].fixed, PLAN[i].known);
				default: begin
					settle_pipeline();
					write_reg(PLAN[i].ridx, PLAN[i].rval);
				end
			endcase
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle_pipeline();
			steady <= (p == 4);
			case (p)
				0: begin
					wv = 16'd512;
					hv = 16'd512;
					cv = TURN_COS[5];
					sv = TURN_SIN[5];
				end
				1: begin
					wv = 16'd1;
					hv = 16'd1;
					cv = 16'h8000;
					sv = 16'h7fff;
				end
				default: begin
					wv = pick_dim();
					hv = pick_dim();
					if ($urandom_range(0, 3) == 0) begin
						cv = COEF_W'($urandom());
						sv = COEF_W'($urandom());
					end else begin
						t  = $urandom_range(0, 7);
						cv = TURN_COS[t];
						sv = TURN_SIN[t];
					end
				end
			endcase
			write_reg(REG_WIDTH, wv);
			write_reg(REG_HEIGHT, hv);
			write_reg(REG_COS, cv);
			write_reg(REG_SIN, sv);
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if ($urandom_range(0, 99) < STORE_PCT)
					store_pixel(pick_coord(width_r), pick_coord(height_r), PIX_W'($urandom()));
				else
					fetch_pixel(pick_coord(width_r), pick_coord(height_r), 1'b0, '0);
			end
		end

		settle_pipeline();
		if (n_bad == 0 && pending_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
